[design/sorted_timer_deadline_queue_macros.svh]
// assertion helpers for the timer queue
`ifndef SORTED_TIMER_DEADLINE_QUEUE_MACROS_SVH
`define SORTED_TIMER_DEADLINE_QUEUE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define STDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[design/stdq_pkg.sv]
package stdq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WALK,
    ST_DONE
  } state_e;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DELAY = 2'd1;
  localparam logic [1:0] STATUS_FULL       = 2'd2;

  localparam int DEADLINE_W = 64;
  localparam int TAG_W      = 8;
  localparam int DELAY_W    = 16;
  localparam int FREQ_W     = 32;
  localparam int PROD_W     = DELAY_W + FREQ_W;
  localparam int STATUS_W   = 2;
  localparam int HELD_W     = 5;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_TICK_FREQUENCY = 3'd0;
  localparam logic [FREQ_W-1:0]     TICK_FREQUENCY_RESET = 32'd62500000;

  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [TAG_W-1:0]      tag;
  } entry_t;

endpackage

[design/sorted_timer_deadline_queue.sv]
// channel  | handshake                        | payload
// ---------+----------------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o          | now_count_i, delay_seconds_i, entry_tag_i
// out      | out_valid_o / out_ready_i        | status_o, became_earliest_o,
//          |                                  | earliest_deadline_o, earliest_tag_o,
//          |                                  | entries_held_o
// config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// an insert runs multiply, add, a walk over the entry ram that writes the new entry at
// its place and moves each later one up by one, then the output load; a rejected beat
// (zero delay or full queue) goes straight to the output load. one beat is in flight at
// a time; it can be accepted while a result still waits, but its own result then stalls
// until the waiting one is taken. reset clears the control and output-valid registers and
// the fill count and restores the tick frequency; the entry ram is not cleared.
module sorted_timer_deadline_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [stdq_pkg::DEADLINE_W-1:0]   now_count_i,
  input  logic [stdq_pkg::DELAY_W-1:0]      delay_seconds_i,
  input  logic [stdq_pkg::TAG_W-1:0]        entry_tag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [stdq_pkg::STATUS_W-1:0]     status_o,
  output logic                              became_earliest_o,
  output logic [stdq_pkg::DEADLINE_W-1:0]   earliest_deadline_o,
  output logic [stdq_pkg::TAG_W-1:0]        earliest_tag_o,
  output logic [stdq_pkg::HELD_W-1:0]       entries_held_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stdq_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stdq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stdq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  `include "sorted_timer_deadline_queue_macros.svh"

  localparam int AddrW  = $clog2(QUEUE_DEPTH);
  localparam int FillW  = $clog2(QUEUE_DEPTH + 1);
  localparam int EntryW = $bits(stdq_pkg::entry_t);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  stdq_pkg::state_e state_q, state_d;

  logic [FillW-1:0]                  fill_q, fill_d;
  logic [FillW-1:0]                  idx_q, idx_d;
  logic                              placed_q, placed_d;
  logic                              force_q, force_d;
  logic                              became_q, became_d;
  logic [stdq_pkg::STATUS_W-1:0]     status_q, status_d;
  stdq_pkg::entry_t                  carry_q, carry_d;
  stdq_pkg::entry_t                  head_q, head_d;
  logic [stdq_pkg::DEADLINE_W-1:0]   now_q;
  logic [stdq_pkg::DELAY_W-1:0]      delay_q;
  logic [stdq_pkg::TAG_W-1:0]        tag_q;
  logic [stdq_pkg::PROD_W-1:0]       prod_q;
  logic [stdq_pkg::DEADLINE_W-1:0]   deadline_q;
  logic [stdq_pkg::FREQ_W-1:0]       tick_freq_q;

  logic                              out_valid_q;
  logic [stdq_pkg::STATUS_W-1:0]     out_status_q;
  logic                              out_became_q;
  logic [stdq_pkg::DEADLINE_W-1:0]   out_deadline_q;
  logic [stdq_pkg::TAG_W-1:0]        out_tag_q;
  logic [stdq_pkg::HELD_W-1:0]       out_held_q;

  logic                              in_beat;
  logic                              out_load;
  logic                              at_end;
  logic                              take_new;
  logic [FillW:0]                    idx_nxt;
  stdq_pkg::entry_t                  new_entry;
  stdq_pkg::entry_t                  rd_entry;
  logic [EntryW-1:0]                 ram_rdata;
  logic                              ram_we;
  logic [AddrW-1:0]                  ram_waddr;
  stdq_pkg::entry_t                  ram_wdata;
  logic                              ram_re;
  logic [AddrW-1:0]                  ram_raddr;
  logic                              cfg_write;

  assign in_ready_o = (state_q == stdq_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == stdq_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign rd_entry  = stdq_pkg::entry_t'(ram_rdata);
  assign new_entry = '{deadline: deadline_q, tag: tag_q};
  assign at_end    = (idx_q == fill_q);
  assign idx_nxt   = {1'b0, idx_q} + 1'b1;
  // new entry lands before the first larger one, or right after the first equal one
  assign take_new  = !placed_q && (at_end || force_q || (deadline_q < rd_entry.deadline));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stdq_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (delay_seconds_i == '0 || fill_q == FillMax) begin
            state_d = stdq_pkg::ST_DONE;
          end else begin
            state_d = stdq_pkg::ST_MUL;
          end
        end
      end
      stdq_pkg::ST_MUL:  state_d = stdq_pkg::ST_ADD;
      stdq_pkg::ST_ADD:  state_d = stdq_pkg::ST_WALK;
      stdq_pkg::ST_WALK: begin
        if (at_end) begin
          state_d = stdq_pkg::ST_DONE;
        end
      end
      stdq_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = stdq_pkg::ST_IDLE;
        end
      end
      default: state_d = stdq_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    fill_d    = fill_q;
    idx_d     = idx_q;
    placed_d  = placed_q;
    force_d   = force_q;
    became_d  = became_q;
    status_d  = status_q;
    carry_d   = carry_q;
    head_d    = head_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = new_entry;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      stdq_pkg::ST_IDLE: begin
        if (in_beat) begin
          idx_d    = '0;
          placed_d = 1'b0;
          force_d  = 1'b0;
          became_d = 1'b0;
          if (delay_seconds_i == '0) begin
            status_d = stdq_pkg::STATUS_ZERO_DELAY;
          end else if (fill_q == FillMax) begin
            status_d = stdq_pkg::STATUS_FULL;
          end else begin
            status_d = stdq_pkg::STATUS_OK;
          end
        end
      end
      stdq_pkg::ST_ADD: begin
        ram_re    = (fill_q != '0);
        ram_raddr = '0;
      end
      stdq_pkg::ST_WALK: begin
        // from the insert point on, every entry moves up by one
        if (placed_q || take_new) begin
          ram_we    = 1'b1;
          ram_wdata = placed_q ? carry_q : new_entry;
          carry_d   = rd_entry;
        end
        if (take_new) begin
          placed_d = 1'b1;
          if (idx_q == '0) begin
            became_d = 1'b1;
            head_d   = new_entry;
          end
        end else if (!placed_q && !at_end && deadline_q == rd_entry.deadline) begin
          force_d = 1'b1;
        end
        ram_re    = !at_end && (idx_nxt < {1'b0, fill_q});
        ram_raddr = idx_nxt[AddrW-1:0];
        idx_d     = idx_nxt[FillW-1:0];
        if (at_end) begin
          fill_d = fill_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stdq_pkg::ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      placed_q    <= 1'b0;
      force_q     <= 1'b0;
      became_q    <= 1'b0;
      status_q    <= stdq_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
      tick_freq_q <= stdq_pkg::TICK_FREQUENCY_RESET;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      placed_q <= placed_d;
      force_q  <= force_d;
      became_q <= became_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        tick_freq_q <= pwdata[stdq_pkg::FREQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    head_q  <= head_d;
    if (in_beat) begin
      now_q   <= now_count_i;
      delay_q <= delay_seconds_i;
      tag_q   <= entry_tag_i;
    end
    if (state_q == stdq_pkg::ST_MUL) begin
      prod_q <= delay_q * tick_freq_q;
    end
    if (state_q == stdq_pkg::ST_ADD) begin
      deadline_q <= now_q + stdq_pkg::DEADLINE_W'(prod_q);
    end
    if (out_load) begin
      out_status_q   <= status_q;
      out_became_q   <= became_q;
      out_deadline_q <= (fill_q != '0) ? head_q.deadline : '0;
      out_tag_q      <= (fill_q != '0) ? head_q.tag : '0;
      out_held_q     <= stdq_pkg::HELD_W'(fill_q);
    end
  end

  stdq_ram #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // config port
  assign cfg_write = psel && penable && pwrite && (paddr == stdq_pkg::ADDR_TICK_FREQUENCY);
  assign pready    = 1'b1;
  assign prdata    = (paddr == stdq_pkg::ADDR_TICK_FREQUENCY) ?
                     stdq_pkg::APB_DATA_W'(tick_freq_q) : '0;

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign became_earliest_o   = out_became_q;
  assign earliest_deadline_o = out_deadline_q;
  assign earliest_tag_o      = out_tag_q;
  assign entries_held_o      = out_held_q;

  `STDQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FillMax, "fill count above queue depth")
  `STDQ_ASSERT_NXT(a_fill_step, 1'b1,
    (fill_q == $past(fill_q)) || ((state_q == stdq_pkg::ST_DONE) && (fill_q == $past(fill_q) + 1'b1)),
    "fill count moved other than by one insert")
  `STDQ_ASSERT_IMP(a_became_ok, out_valid_o && became_earliest_o,
    status_o == stdq_pkg::STATUS_OK, "new head reported on a rejected beat")
  `STDQ_ASSERT_IMP(a_ok_nonempty, out_valid_o && (status_o == stdq_pkg::STATUS_OK),
    entries_held_o != '0 || QUEUE_DEPTH > 31, "insert reported with empty queue")

endmodule

[design/stdq_ram.sv]
module stdq_ram #(
  parameter int Width = 72,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
